[hw/rtl/twseg_pkg.sv]
// Types, constants and decode functions shared by the two-wire segment display writer.
`default_nettype none

package twseg_pkg;

  localparam int DECIMAL_DIGITS = 3;
  localparam int IDX_W = (DECIMAL_DIGITS > 1) ? $clog2(DECIMAL_DIGITS) : 1;
  localparam logic [6:0] LAST_STEP = 7'd124;

  localparam logic [1:0] OP_IDLE = 2'd0;
  localparam logic [1:0] OP_HEX  = 2'd1;
  localparam logic [1:0] OP_DEC  = 2'd2;

  localparam logic [7:0] CMD_DATA  = 8'h40;
  localparam logic [7:0] ADDR_BASE = 8'hC0;
  localparam logic [7:0] CTRL_ON   = 8'h88;

  typedef enum logic [1:0] {
    BYTE_CMD  = 2'd0,
    BYTE_ADDR = 2'd1,
    BYTE_SEG  = 2'd2,
    BYTE_CTRL = 2'd3
  } byte_sel_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [1:0] position;
    logic [3:0] hex_digit;
    logic [9:0] number;
  } in_word_t;

  typedef struct packed {
    logic clock_level;
    logic data_level;
    logic busy_res;
    logic rejected;
  } out_word_t;

  typedef logic [DECIMAL_DIGITS-1:0][3:0] digits_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [1:0] position;
    logic [3:0] hex_digit;
    digits_t    digits;
  } item_t;

  typedef struct packed {
    logic      clk_we;
    logic      clk_val;
    logic      dat_we;
    logic      dat_from_byte;
    logic      dat_lit;
    byte_sel_e byte_sel;
    logic [2:0] bit_idx;
  } act_t;

  typedef struct packed {
    logic valid;
    logic stall;
  } stage_hs_t;

  function automatic logic [7:0] seg_rom(logic [3:0] d);
    logic [7:0] r;
    case (d)
      4'h0: r = 8'b00111111;
      4'h1: r = 8'h06;
      4'h2: r = 8'h5B;
      4'h3: r = 8'h4F;
      4'h4: r = 8'h66;
      4'h5: r = 8'h6D;
      4'h6: r = 8'h7D;
      4'h7: r = 8'h07;
      4'h8: r = 8'h7F;
      4'h9: r = 8'h6F;
      4'hA: r = 8'h77;
      4'hB: r = 8'h7C;
      4'hC: r = 8'h39;
      4'hD: r = 8'h5E;
      4'hE: r = 8'h79;
      4'hF: r = 8'b01110001;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic digits_t split_digits(logic [9:0] n);
    digits_t    d;
    logic [9:0] r;
    logic [17:0] prod;
    logic [9:0] q;
    r = n;
    for (int i = 0; i < DECIMAL_DIGITS; i++) begin
      prod = 18'(r) * 18'd205;
      q = 10'(prod >> 11);
      d[i] = 4'(r - 10'(q * 10'd10));
      r = q;
    end
    return d;
  endfunction

  function automatic act_t start_act(logic [1:0] k);
    act_t a;
    a = '0;
    case (k)
      2'd0: begin a.dat_we = 1'b1; a.dat_lit = 1'b1; end
      2'd1: begin a.clk_we = 1'b1; a.clk_val = 1'b1; end
      2'd2: begin a.dat_we = 1'b1; a.dat_lit = 1'b0; end
      default: begin a.clk_we = 1'b1; a.clk_val = 1'b0; end
    endcase
    return a;
  endfunction

  function automatic act_t stop_act(logic [1:0] k);
    act_t a;
    a = '0;
    case (k)
      2'd0: begin a.dat_we = 1'b1; a.dat_lit = 1'b0; end
      2'd1: begin a.clk_we = 1'b1; a.clk_val = 1'b1; end
      default: begin a.dat_we = 1'b1; a.dat_lit = 1'b1; end
    endcase
    return a;
  endfunction

  function automatic act_t byte_act(logic [4:0] k, byte_sel_e sel);
    act_t a;
    logic [8:0] prod;
    logic [2:0] bit_n;
    logic [4:0] rem;
    a = '0;
    prod = 9'(k) * 9'd11;
    bit_n = prod[7:5];
    rem = 5'(k - (5'(bit_n) * 5'd3));
    a.byte_sel = sel;
    a.bit_idx = bit_n;
    if (k < 5'd24) begin
      if (rem == 5'd0) begin
        a.dat_we = 1'b1;
        a.dat_from_byte = 1'b1;
      end else begin
        a.clk_we = 1'b1;
        a.clk_val = (rem == 5'd1);
      end
    end else begin
      a.clk_we = 1'b1;
      a.clk_val = (k == 5'd24);
    end
    return a;
  endfunction

  function automatic act_t step_action(logic [6:0] s);
    act_t a;
    if (s < 7'd4) a = start_act(2'(s));
    else if (s < 7'd30) a = byte_act(5'(s - 7'd4), BYTE_CMD);
    else if (s < 7'd33) a = stop_act(2'(s - 7'd30));
    else if (s < 7'd37) a = start_act(2'(s - 7'd33));
    else if (s < 7'd63) a = byte_act(5'(s - 7'd37), BYTE_ADDR);
    else if (s < 7'd89) a = byte_act(5'(s - 7'd63), BYTE_SEG);
    else if (s < 7'd92) a = stop_act(2'(s - 7'd89));
    else if (s < 7'd96) a = start_act(2'(s - 7'd92));
    else if (s < 7'd122) a = byte_act(5'(s - 7'd96), BYTE_CTRL);
    else a = stop_act(2'(s - 7'd122));
    return a;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/twseg_in_stage.sv]
// Input register: captures a request word and splits the decimal number into digits.
`default_nettype none

module twseg_in_stage
  import twseg_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_word_t  in_data_i,
  output stage_hs_t      hs_o,
  input  wire logic      seq_stall_i,
  output item_t          item_o
);

  logic  vld_q, vld_d;
  item_t item_q;
  logic  accept;

  assign in_stall_o = vld_q && seq_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign vld_d      = accept || (vld_q && seq_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.opcode    <= in_data_i.opcode;
      item_q.position  <= in_data_i.position;
      item_q.hex_digit <= in_data_i.hex_digit;
      item_q.digits    <= split_digits(in_data_i.number);
    end
  end

  assign hs_o.valid = vld_q;
  assign hs_o.stall = in_stall_o;
  assign item_o     = item_q;

endmodule

`default_nettype wire

[hw/rtl/twseg_seq.sv]
// Pin sequencer: advances one pin write per word and registers the result word.
`default_nettype none

module twseg_seq
  import twseg_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire stage_hs_t hs_i,
  input  wire item_t     item_i,
  output logic           stall_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_word_t      out_data_o
);

  logic       out_vld_q, out_vld_d;
  out_word_t  out_q, out_d;
  logic       clk_pin_q, clk_pin_d;
  logic       dat_pin_q, dat_pin_d;
  logic       active_q, active_d;
  logic       dec_q, dec_d;
  logic [6:0] sub_q, sub_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  digits_t    digits_q, digits_d;
  logic [1:0] pos_q, pos_d;

  logic       load, req, start, rej, run;
  logic [6:0] sub_c;
  logic [IDX_W-1:0] idx_c;
  logic [1:0] pos_c;
  logic [3:0] digit_c;
  logic [7:0] byte_c;
  act_t       act;

  assign stall_o = out_vld_q && out_stall_i;
  assign load    = hs_i.valid && !stall_o;
  assign req     = (item_i.opcode == OP_HEX) || (item_i.opcode == OP_DEC);
  assign start   = req && !active_q;
  assign rej     = req && active_q;
  assign run     = start || active_q;

  always_comb begin
    dec_d    = dec_q;
    pos_d    = pos_q;
    digits_d = digits_q;
    if (start) begin
      dec_d = (item_i.opcode == OP_DEC);
      if (item_i.opcode == OP_DEC) begin
        digits_d = item_i.digits;
      end else begin
        pos_d = item_i.position;
        digits_d[0] = item_i.hex_digit;
      end
    end
    sub_c   = start ? 7'd0 : sub_q;
    idx_c   = start ? '0 : idx_q;
    pos_c   = dec_d ? 2'(3'(DECIMAL_DIGITS) - 3'(idx_c)) : pos_d;
    digit_c = dec_d ? digits_d[idx_c] : digits_d[0];
    act     = step_action(sub_c);
    case (act.byte_sel)
      BYTE_CMD:  byte_c = CMD_DATA;
      BYTE_ADDR: byte_c = ADDR_BASE | {6'd0, pos_c};
      BYTE_SEG:  byte_c = seg_rom(digit_c);
      BYTE_CTRL: byte_c = CTRL_ON;
      default:   byte_c = CMD_DATA;
    endcase

    clk_pin_d = clk_pin_q;
    dat_pin_d = dat_pin_q;
    active_d  = active_q;
    sub_d     = sub_q;
    idx_d     = idx_q;
    if (run) begin
      if (act.clk_we) begin
        clk_pin_d = act.clk_val;
      end
      if (act.dat_we) begin
        dat_pin_d = act.dat_from_byte ? byte_c[act.bit_idx] : act.dat_lit;
      end
      active_d = 1'b1;
      if (sub_c == LAST_STEP) begin
        sub_d = 7'd0;
        if (dec_d && (idx_c != IDX_W'(DECIMAL_DIGITS - 1))) begin
          idx_d = IDX_W'(idx_c + 1'b1);
        end else begin
          idx_d    = '0;
          active_d = 1'b0;
        end
      end else begin
        sub_d = 7'(sub_c + 7'd1);
        idx_d = idx_c;
      end
    end

    out_d.clock_level = clk_pin_d;
    out_d.data_level  = dat_pin_d;
    out_d.busy_res    = active_d;
    out_d.rejected    = rej;
  end

  assign out_vld_d = load || (out_vld_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      clk_pin_q <= 1'b1;
      dat_pin_q <= 1'b0;
      active_q  <= 1'b0;
      dec_q     <= 1'b0;
      sub_q     <= 7'd0;
      idx_q     <= '0;
    end else begin
      out_vld_q <= out_vld_d;
      if (load) begin
        clk_pin_q <= clk_pin_d;
        dat_pin_q <= dat_pin_d;
        active_q  <= active_d;
        dec_q     <= dec_d;
        sub_q     <= sub_d;
        idx_q     <= idx_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q    <= out_d;
      digits_q <= digits_d;
      pos_q    <= pos_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_idle_counters_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (sub_q == 7'd0) && (idx_q == '0))
    else $error("idle sequencer holds a nonzero step");

  a_step_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sub_q <= LAST_STEP) && (32'(idx_q) < DECIMAL_DIGITS))
    else $error("step counter out of range");

  a_hex_single_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !dec_q |-> (idx_q == '0))
    else $error("hex write moved past its digit");

  a_reject_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && rej) |=> (out_q.rejected && $past(active_q)))
    else $error("request rejected while idle");

  a_start_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && start) |=> active_q && out_q.busy_res && !out_q.rejected)
    else $error("accepted request did not start a sequence");
`endif

endmodule

`default_nettype wire

[hw/rtl/two_wire_segment_display_writer.sv]
// Top level of the two-wire segment display writer.
`default_nettype none

// Each input word is one tick and yields exactly one result word carrying the clock and data
// pin levels after that tick, the busy flag and a reject flag. One word is taken every cycle
// while the output does not stall; a word passes an input register and then the result
// register before its result is on the output; a stalled output holds both registers and
// stalls the input. A hex-digit request (opcode 1) runs for 125 ticks, a decimal request
// (opcode 2) for 375 ticks showing the value mod 1000 at positions 3, 2 and 1. A request
// that arrives while busy is dropped and flagged.

module two_wire_segment_display_writer
  import twseg_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_word_t in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_word_t     out_data_o
);

  stage_hs_t hs;
  item_t     item;
  logic      seq_stall;

  twseg_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .hs_o        (hs),
    .seq_stall_i (seq_stall),
    .item_o      (item)
  );

  twseg_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hs_i        (hs),
    .item_i      (item),
    .stall_o     (seq_stall),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
